FILE: rtl/ptwc_pkg.sv
package ptwc_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int KEY_W      = 29;
    localparam int SEG_SHIFT  = 0;
    localparam int CID_SHIFT  = 11;
    localparam int PLID_SHIFT = 19;
    localparam int UD_SHIFT   = 27;

    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_LOAD    = 2'd1;
    localparam logic [1:0] OP_FORWARD = 2'd2;
    localparam logic [1:0] OP_REVERSE = 2'd3;

    localparam logic [1:0] TY_NONE = 2'd0;
    localparam logic [1:0] TY_ISQR = 2'd1;
    localparam logic [1:0] TY_QUAD = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_NO_METHOD = 3'd2;
    localparam logic [2:0] ST_FEW_COEFF = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_SRCH_CHK,
        S_READ,
        S_DISPATCH,
        S_SQRT,
        S_DIV,
        S_ISQ_FIN,
        S_MUL_AE,
        S_MUL_AEE,
        S_MUL_BE,
        S_QUAD_FIN,
        S_OUT
    } state_t;

    function automatic logic signed [63:0] sat32(input logic signed [65:0] x);
        if (x > 66'sd2147483647)
            return 64'sd2147483647;
        else if (x < -66'sd2147483648)
            return -64'sd2147483648;
        else
            return x[63:0];
    endfunction

endpackage

FILE: rtl/ptwc_sqrtdiv.sv
module ptwc_sqrtdiv
    import ptwc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sqrt_start,
    input  logic [63:0] sqrt_in,
    input  logic        div_start,
    input  logic [63:0] dividend,
    output logic        busy,
    output logic [63:0] result
);

    // shared restoring unit: 32 steps for sqrt (64-bit radicand), 64 steps for divide
    logic [63:0] num_reg, num_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        mode_reg, mode_next;
    logic        busy_reg, busy_next;

    logic [65:0] trial;
    logic [64:0] dtrial;

    always_comb
    begin
        num_next  = num_reg;
        acc_next  = acc_reg;
        res_next  = res_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        mode_next = mode_reg;
        busy_next = busy_reg;
        trial     = '0;
        dtrial    = '0;
        if (sqrt_start)
        begin
            num_next  = sqrt_in;
            acc_next  = '0;
            res_next  = '0;
            cnt_next  = 7'd32;
            mode_next = 1'b0;
            busy_next = 1'b1;
        end
        else if (div_start)
        begin
            den_next  = (res_reg == 64'd0) ? 64'd1 : res_reg;
            num_next  = dividend;
            acc_next  = '0;
            res_next  = '0;
            cnt_next  = 7'd64;
            mode_next = 1'b1;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!mode_reg)
            begin
                trial = {acc_reg, num_reg[63:62]} - {res_reg[63:0], 2'b01};
                if (!trial[65])
                begin
                    acc_next = trial[63:0];
                    res_next = {res_reg[62:0], 1'b1};
                end
                else
                begin
                    acc_next = {acc_reg[61:0], num_reg[63:62]};
                    res_next = {res_reg[62:0], 1'b0};
                end
                num_next = {num_reg[61:0], 2'b00};
            end
            else
            begin
                dtrial = {acc_reg, num_reg[63]} - {1'b0, den_reg};
                if (!dtrial[64])
                begin
                    acc_next = dtrial[63:0];
                    res_next = {res_reg[62:0], 1'b1};
                end
                else
                begin
                    acc_next = {acc_reg[62:0], num_reg[63]};
                    res_next = {res_reg[62:0], 1'b0};
                end
                num_next = {num_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            mode_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            mode_reg <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        acc_reg <= acc_next;
        res_reg <= res_next;
        den_reg <= den_next;
    end

    assign busy   = busy_reg;
    assign result = res_reg;

endmodule

FILE: rtl/per_channel_time_walk_correction.sv
// Lookup scans stored entries one at a time, through a search state and a check state;
// inverse-sqrt correction then runs in the shared shift-subtract
// root/divide unit, quadratic through one shared 32x32 multiplier.
// One item at a time: s_tready is low until the result beat is taken.
// Reset (rst_n, async, active low) empties the table and returns to idle.
module per_channel_time_walk_correction
    import ptwc_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // op, crate_id, plane_id, segment, side, corr_type, coeff_count,
    // coeff_a, coeff_b, coeff_c, hit_time, pulse_height
    input  logic [199:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // corrected_time, status
    output logic [39:0]  m_tdata
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic [1:0]  in_op;
    logic [7:0]  in_crate, in_plane;
    logic [9:0]  in_seg;
    logic [1:0]  in_side, in_type, in_count;
    logic signed [31:0] in_a, in_b, in_c, in_t, in_e;

    assign in_op    = s_tdata[1:0];
    assign in_crate = s_tdata[9:2];
    assign in_plane = s_tdata[17:10];
    assign in_seg   = s_tdata[27:18];
    assign in_side  = s_tdata[29:28];
    assign in_type  = s_tdata[31:30];
    assign in_count = s_tdata[33:32];
    assign in_a     = s_tdata[65:34];
    assign in_b     = s_tdata[97:66];
    assign in_c     = s_tdata[129:98];
    assign in_t     = s_tdata[161:130];
    assign in_e     = s_tdata[193:162];

    logic [KEY_W-1:0] mem_key  [TABLE_DEPTH];
    logic [99:0]      mem_data [TABLE_DEPTH];

    state_t state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic [1:0]  op_reg, op_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [1:0]  ty_reg, ty_next, cnt_reg, cnt_next;
    logic signed [31:0] a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic signed [31:0] t_reg, t_next, e_reg, e_next;
    logic signed [31:0] res_reg, res_next;
    logic [2:0]  st_reg, st_next;
    logic [IDX_W-1:0] hit_reg, hit_next;
    logic        found_reg, found_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [63:0] p_reg;
    logic signed [31:0] mx, my;
    logic [KEY_W-1:0] rkey_reg;
    logic [99:0] rdata_reg;
    logic        mwr;
    logic [IDX_W-1:0] widx;
    logic [IDX_W-1:0] ridx;

    logic        sq_start, dv_start, u_busy;
    logic [63:0] sq_in, dv_in, u_res;
    logic signed [32:0] diff_eb;
    logic [31:0] adist;
    logic [31:0] amag;
    logic signed [63:0] q;
    logic signed [65:0] tmp;

    ptwc_sqrtdiv u_unit (
        .clk        (clk),
        .rst_n      (rst_n),
        .sqrt_start (sq_start),
        .sqrt_in    (sq_in),
        .div_start  (dv_start),
        .dividend   (dv_in),
        .busy       (u_busy),
        .result     (u_res)
    );

    always_ff @(posedge clk)
    begin
        p_reg     <= mx * my;
        rkey_reg  <= mem_key[ridx];
        rdata_reg <= mem_data[ridx];
        if (mwr)
        begin
            mem_key[widx]  <= key_reg;
            mem_data[widx] <= {ty_reg, cnt_reg, a_reg, b_reg, c_reg};
        end
    end

    assign ridx = (state_reg == S_SEARCH) ? scan_reg[IDX_W-1:0] : hit_reg;

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        scan_next  = scan_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        ty_next    = ty_reg;
        cnt_next   = cnt_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        t_next     = t_reg;
        e_next     = e_reg;
        res_next   = res_reg;
        st_next    = st_reg;
        hit_next   = hit_reg;
        found_next = found_reg;
        acc_next   = acc_reg;
        mx         = a_reg;
        my         = e_reg;
        mwr        = 1'b0;
        widx       = hit_reg;
        sq_start   = 1'b0;
        dv_start   = 1'b0;
        diff_eb    = 33'(e_reg) - 33'(b_reg);
        adist      = diff_eb[32] ? 32'(-diff_eb) : diff_eb[31:0];
        if (adist == 32'd0)
            adist = 32'd1;
        sq_in      = 64'(adist) << FRAC_BITS;
        amag       = a_reg[31] ? 32'(-33'(a_reg)) : a_reg;
        dv_in      = 64'(amag) << FRAC_BITS;
        q          = a_reg[31] ? -$signed(u_res) : $signed(u_res);
        tmp        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next  = in_op;
                    key_next = KEY_W'(in_seg) | (KEY_W'(in_crate) << CID_SHIFT)
                             | (KEY_W'(in_plane) << PLID_SHIFT)
                             | (KEY_W'(in_side) << UD_SHIFT);
                    ty_next  = in_type;
                    cnt_next = in_count;
                    a_next   = in_a;
                    b_next   = in_b;
                    c_next   = in_c;
                    t_next   = in_t;
                    e_next   = in_e;
                    res_next = in_t;
                    st_next  = ST_OK;
                    scan_next  = '0;
                    found_next = 1'b0;
                    if (in_op == OP_CLEAR)
                    begin
                        fill_next  = '0;
                        state_next = S_OUT;
                    end
                    else
                        state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (scan_reg >= fill_reg)
                    state_next = S_DISPATCH;
                else
                    state_next = S_SRCH_CHK;
            end
            S_SRCH_CHK:
            begin
                if (rkey_reg == key_reg)
                begin
                    found_next = 1'b1;
                    hit_next   = scan_reg[IDX_W-1:0];
                    state_next = (op_reg == OP_LOAD) ? S_DISPATCH : S_READ;
                end
                else
                begin
                    scan_next  = scan_reg + CNT_W'(1);
                    state_next = S_SEARCH;
                end
            end
            S_READ:
            begin
                state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                state_next = S_OUT;
                if (op_reg == OP_LOAD)
                begin
                    if (found_reg)
                        mwr = 1'b1;
                    else if (fill_reg < CNT_W'(TABLE_DEPTH))
                    begin
                        mwr       = 1'b1;
                        widx      = fill_reg[IDX_W-1:0];
                        fill_next = fill_reg + CNT_W'(1);
                    end
                    else
                        st_next = ST_FULL;
                end
                else if (!found_reg)
                    st_next = ST_NOT_FOUND;
                else
                begin
                    ty_next  = rdata_reg[99:98];
                    cnt_next = rdata_reg[97:96];
                    a_next   = rdata_reg[95:64];
                    b_next   = rdata_reg[63:32];
                    c_next   = rdata_reg[31:0];
                    if (rdata_reg[99:98] == TY_NONE)
                        st_next = ST_OK;
                    else if (!(rdata_reg[99:98] == TY_ISQR
                               || (rdata_reg[99:98] == TY_QUAD && op_reg == OP_FORWARD)))
                        st_next = ST_NO_METHOD;
                    else if (rdata_reg[97:96] != 2'd3)
                        st_next = ST_FEW_COEFF;
                    else if (rdata_reg[99:98] == TY_ISQR)
                        state_next = S_SQRT;
                    else
                        state_next = S_MUL_AE;
                end
            end
            S_SQRT:
            begin
                sq_start   = 1'b1;
                state_next = S_DIV;
                found_next = 1'b0;
            end
            S_DIV:
            begin
                if (!u_busy)
                begin
                    if (!found_reg)
                    begin
                        dv_start   = 1'b1;
                        found_next = 1'b1;
                    end
                    else
                        state_next = S_ISQ_FIN;
                end
            end
            S_ISQ_FIN:
            begin
                if (op_reg == OP_FORWARD)
                    tmp = 66'(t_reg) - 66'(q) + 66'(c_reg);
                else
                    tmp = 66'(t_reg) + 66'(q) - 66'(c_reg);
                res_next   = 32'(sat32(tmp));
                state_next = S_OUT;
            end
            S_MUL_AE:
            begin
                state_next = S_MUL_AEE;
            end
            S_MUL_AEE:
            begin
                tmp        = 66'(p_reg >>> FRAC_BITS);
                a_next     = 32'(sat32(tmp));
                mx         = 32'(sat32(tmp));
                state_next = S_MUL_BE;
            end
            S_MUL_BE:
            begin
                acc_next   = p_reg >>> FRAC_BITS;
                mx         = b_reg;
                state_next = S_QUAD_FIN;
            end
            S_QUAD_FIN:
            begin
                tmp = 66'(t_reg) - (66'(acc_reg) + 66'(p_reg >>> FRAC_BITS) + 66'(c_reg));
                res_next   = 32'(sat32(tmp));
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (m_tready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        op_reg   <= op_next;
        key_reg  <= key_next;
        ty_reg   <= ty_next;
        cnt_reg  <= cnt_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        t_reg    <= t_next;
        e_reg    <= e_next;
        res_reg  <= res_next;
        st_reg   <= st_next;
        hit_reg  <= hit_next;
        acc_reg  <= acc_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {5'd0, st_reg, res_reg};

endmodule
